// ----- sv/pfd_pkg.sv -----
package pfd_pkg;

    // channel slots held in the pulse store
    localparam int MAX_CHANNELS = 16;
    localparam int SLOT_W       = $clog2(MAX_CHANNELS);
    localparam int EMIT_W       = $clog2(MAX_CHANNELS + 1);

    localparam int COUNT_W      = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int TIME_W       = 16;
    localparam int CENTER_W     = 15;
    localparam int TRAVEL_W     = 14;
    localparam int MAXCH_W      = 5;
    localparam int VALUE_W      = 16;
    localparam int CHAN_W       = 4;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_US   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_US   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_US      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANNEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP    = 3'd4;

    localparam logic [CENTER_W-1:0] RST_CENTER_US = 15'd1520;
    localparam logic [TRAVEL_W-1:0] RST_TRAVEL_US = 14'd600;
    localparam logic [MAXCH_W-1:0]  RST_MAX_CH    = 5'd16;
    localparam logic [TIME_W-1:0]   RST_SYNC_GAP  = 16'd15000;

    // normalized full deflection
    localparam logic [VALUE_W-1:0] NORM_POS = 16'd256;
    localparam logic [VALUE_W-1:0] NORM_NEG = 16'hFF00;

    // divider: (delta << 5) / (travel >> 2)
    localparam int DVD_W     = 20;
    localparam int DSR_W     = TRAVEL_W - 2;
    localparam int DIV_STEPS = DVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        MODE_STARTUP,
        MODE_LISTENING,
        MODE_STABLE,
        MODE_CONFUSED
    } t_mode;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_CLASS,
        SEQ_DIV,
        SEQ_PUT
    } t_seq_state;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

endpackage

// ----- sv/pfd_in_if.sv -----
interface pfd_in_if;
    logic                           valid;
    logic                           ready;
    logic [pfd_pkg::TIME_W-1:0]     edge_time;
    logic                           level_high;

    modport source (output valid, output edge_time, output level_high, input ready);
    modport sink   (input valid, input edge_time, input level_high, output ready);
endinterface

// ----- sv/pfd_out_if.sv -----
interface pfd_out_if;
    logic                               valid;
    logic                               ready;
    logic        [pfd_pkg::CHAN_W-1:0]  channel;
    logic signed [pfd_pkg::VALUE_W-1:0] value;
    logic                               last;

    modport source (output valid, output channel, output value, output last, input ready);
    modport sink   (input valid, input channel, input value, input last, output ready);
endinterface

// ----- sv/pfd_div_unit.sv -----
module pfd_div_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pfd_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [pfd_pkg::DVD_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [pfd_pkg::DCNT_W-1:0]    r_cnt;
    logic [pfd_pkg::DSR_W-1:0]     r_rem;
    logic [pfd_pkg::DSR_W-1:0]     r_dsr;
    // dividend bits shift out the top while quotient bits shift in
    logic [pfd_pkg::DVD_W-1:0]     r_quo;

    logic [pfd_pkg::DSR_W:0]       w_rem_sh;
    logic                          w_ge;
    logic [pfd_pkg::DSR_W:0]       w_rem_sub;

    assign w_rem_sh  = {r_rem, r_quo[pfd_pkg::DVD_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_dsr};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= pfd_pkg::DCNT_W'(pfd_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pfd_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[pfd_pkg::DSR_W-1:0] : w_rem_sh[pfd_pkg::DSR_W-1:0];
            r_quo <= {r_quo[pfd_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- sv/ppm_frame_decoder.sv -----
// PPM frame decoder. Each input item is one pin edge with its 16-bit timer stamp
// (half-microsecond ticks); rising edges are taken and dropped, a falling edge is
// handled as it is accepted. A falling edge that closes a good frame starts a
// readout of the stored channels, one result item per channel, during which no
// input is taken. A channel in microsecond mode, or one clipped at full
// deflection, passes the read, classify and put states; a normalized channel
// also waits on the 20-step restoring divider that all channels share. A full
// 16-channel frame therefore holds the input off for its whole readout, plus
// any output stall. The last result waits in the output register while the next
// edge is already accepted. There is no clearing pass after reset.
module ppm_frame_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pfd_in_if.sink                             i_in,
    pfd_out_if.source                          o_out
);

    // configuration
    logic [pfd_pkg::CENTER_W-1:0]   r_center;
    logic [pfd_pkg::TRAVEL_W-1:0]   r_travel;
    logic                           r_use_us;
    logic [pfd_pkg::MAXCH_W-1:0]    r_max_ch;
    logic [pfd_pkg::TIME_W-1:0]     r_sync_gap;

    // frame tracking
    pfd_pkg::t_mode                 r_mode, n_mode;
    logic [pfd_pkg::TIME_W-1:0]     r_last_edge, n_last_edge;
    logic [pfd_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [pfd_pkg::COUNT_W-1:0]    r_index, n_index;

    // readout sequencer
    pfd_pkg::t_seq_state            r_state, n_state;
    logic [pfd_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [pfd_pkg::EMIT_W-1:0]     r_emit_n, n_emit_n;
    logic [pfd_pkg::TIME_W-1:0]     r_pulse;
    logic [pfd_pkg::VALUE_W-1:0]    r_value, n_value;
    logic                           r_neg, n_neg;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [pfd_pkg::CHAN_W-1:0]     r_out_channel, n_out_channel;
    logic [pfd_pkg::VALUE_W-1:0]    r_out_value, n_out_value;
    logic                           r_out_last, n_out_last;

    // pulse store
    logic [pfd_pkg::TIME_W-1:0]     r_store [pfd_pkg::MAX_CHANNELS];
    logic                           w_st_we;
    logic [pfd_pkg::SLOT_W-1:0]     w_st_addr;

    logic                           w_accept;
    logic [pfd_pkg::TIME_W-1:0]     w_interval;
    logic                           w_sync;
    logic [pfd_pkg::EMIT_W-1:0]     w_slot_lim;
    logic [pfd_pkg::EMIT_W-1:0]     w_emit_n;
    logic                           w_emit;
    logic [pfd_pkg::COUNT_W-1:0]    w_wr_slot;

    logic [pfd_pkg::TIME_W-1:0]     w_c;
    logic [pfd_pkg::TIME_W:0]       w_t;
    logic [pfd_pkg::TIME_W:0]       w_hi;
    logic                           w_above;
    logic                           w_below;
    logic                           w_p_lt_c;
    logic [pfd_pkg::TIME_W-1:0]     w_delta;
    logic [pfd_pkg::DSR_W-1:0]      w_dsr;
    logic [8:0]                     w_mag;
    logic                           w_last_slot;
    logic                           w_out_free;

    pfd_pkg::t_div_req              w_div_req;
    logic                           w_div_done;
    logic [pfd_pkg::DVD_W-1:0]      w_div_quot;

    pfd_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign i_in.ready = (r_state == pfd_pkg::SEQ_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_interval = i_in.edge_time - r_last_edge;
    assign w_sync     = w_interval > r_sync_gap;
    assign w_slot_lim = (r_max_ch > pfd_pkg::EMIT_W'(pfd_pkg::MAX_CHANNELS))
                      ? pfd_pkg::EMIT_W'(pfd_pkg::MAX_CHANNELS) : r_max_ch;
    assign w_emit_n   = (r_count > pfd_pkg::COUNT_W'(w_slot_lim))
                      ? w_slot_lim : r_count[pfd_pkg::EMIT_W-1:0];

    // normalization classify on the registered pulse
    assign w_c      = {r_center, 1'b0};
    assign w_t      = {2'b00, r_travel, 1'b0};
    assign w_hi     = {1'b0, w_c} + w_t;
    assign w_above  = {1'b0, r_pulse} >= w_hi;
    assign w_below  = ({1'b0, r_pulse} + w_t) <= {1'b0, w_c};
    assign w_p_lt_c = r_pulse < w_c;
    assign w_delta  = w_p_lt_c ? (w_c - r_pulse) : (r_pulse - w_c);
    assign w_dsr    = (r_travel[pfd_pkg::TRAVEL_W-1:2] == '0)
                    ? pfd_pkg::DSR_W'(1) : r_travel[pfd_pkg::TRAVEL_W-1:2];
    assign w_mag    = (w_div_quot > pfd_pkg::DVD_W'(256)) ? 9'd256 : w_div_quot[8:0];

    assign w_last_slot = ({1'b0, r_slot} == (r_emit_n - 1'b1));
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_mode        = r_mode;
        n_last_edge   = r_last_edge;
        n_count       = r_count;
        n_index       = r_index;
        n_state       = r_state;
        n_slot        = r_slot;
        n_emit_n      = r_emit_n;
        n_value       = r_value;
        n_neg         = r_neg;
        n_out_valid   = r_out_valid;
        n_out_channel = r_out_channel;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;
        w_st_we       = 1'b0;
        w_wr_slot     = r_count;
        w_emit        = 1'b0;
        w_div_req     = '{start: 1'b0,
                          dividend: {w_delta[14:0], 5'b00000},
                          divisor: w_dsr};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pfd_pkg::SEQ_IDLE: begin
                if (w_accept && !i_in.level_high) begin
                    n_last_edge = i_in.edge_time;
                    unique case (r_mode)
                        pfd_pkg::MODE_LISTENING: begin
                            if (w_sync) begin
                                n_mode  = pfd_pkg::MODE_STABLE;
                                n_index = '0;
                                w_emit  = 1'b1;
                            end else begin
                                w_wr_slot = r_count;
                                w_st_we   = r_count < pfd_pkg::COUNT_W'(w_slot_lim);
                                n_count   = (r_count == pfd_pkg::COUNT_MAX)
                                          ? r_count : r_count + 1'b1;
                            end
                        end
                        pfd_pkg::MODE_STABLE: begin
                            if (w_sync) begin
                                if (r_index == r_count) begin
                                    n_index = '0;
                                    w_emit  = 1'b1;
                                end else begin
                                    n_mode = pfd_pkg::MODE_CONFUSED;
                                end
                            end else begin
                                w_wr_slot = r_index;
                                w_st_we   = r_index < pfd_pkg::COUNT_W'(w_slot_lim);
                                n_index   = (r_index == pfd_pkg::COUNT_MAX)
                                          ? r_index : r_index + 1'b1;
                            end
                        end
                        pfd_pkg::MODE_STARTUP,
                        pfd_pkg::MODE_CONFUSED: begin
                            if (w_sync) begin
                                n_mode  = pfd_pkg::MODE_LISTENING;
                                n_count = '0;
                            end
                        end
                        default: ;
                    endcase
                    if (w_emit && (w_emit_n != '0)) begin
                        n_slot   = '0;
                        n_emit_n = w_emit_n;
                        n_state  = pfd_pkg::SEQ_READ;
                    end
                end
            end
            pfd_pkg::SEQ_READ: begin
                n_state = pfd_pkg::SEQ_CLASS;
            end
            pfd_pkg::SEQ_CLASS: begin
                priority if (r_use_us) begin
                    n_value = {1'b0, r_pulse[pfd_pkg::TIME_W-1:1]};
                    n_state = pfd_pkg::SEQ_PUT;
                end else if (w_above) begin
                    n_value = pfd_pkg::NORM_POS;
                    n_state = pfd_pkg::SEQ_PUT;
                end else if (w_below) begin
                    n_value = pfd_pkg::NORM_NEG;
                    n_state = pfd_pkg::SEQ_PUT;
                end else begin
                    n_neg           = w_p_lt_c;
                    w_div_req.start = 1'b1;
                    n_state         = pfd_pkg::SEQ_DIV;
                end
            end
            pfd_pkg::SEQ_DIV: begin
                if (w_div_done) begin
                    n_value = r_neg ? -pfd_pkg::VALUE_W'(w_mag) : pfd_pkg::VALUE_W'(w_mag);
                    n_state = pfd_pkg::SEQ_PUT;
                end
            end
            pfd_pkg::SEQ_PUT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_channel = pfd_pkg::CHAN_W'(r_slot);
                    n_out_value   = r_value;
                    n_out_last    = w_last_slot;
                    if (w_last_slot) begin
                        n_state = pfd_pkg::SEQ_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = pfd_pkg::SEQ_READ;
                    end
                end
            end
            default: n_state = pfd_pkg::SEQ_IDLE;
        endcase
    end

    assign w_st_addr = w_wr_slot[pfd_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= pfd_pkg::RST_CENTER_US;
            r_travel   <= pfd_pkg::RST_TRAVEL_US;
            r_use_us   <= 1'b0;
            r_max_ch   <= pfd_pkg::RST_MAX_CH;
            r_sync_gap <= pfd_pkg::RST_SYNC_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfd_pkg::CFG_CENTER_US:   r_center   <= i_cfg_data[pfd_pkg::CENTER_W-1:0];
                pfd_pkg::CFG_TRAVEL_US:   r_travel   <= i_cfg_data[pfd_pkg::TRAVEL_W-1:0];
                pfd_pkg::CFG_USE_US:      r_use_us   <= i_cfg_data[0];
                pfd_pkg::CFG_MAX_CHANNEL: r_max_ch   <= i_cfg_data[pfd_pkg::MAXCH_W-1:0];
                pfd_pkg::CFG_SYNC_GAP:    r_sync_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfd_pkg::SEQ_IDLE;
            r_mode      <= pfd_pkg::MODE_STARTUP;
            r_last_edge <= '0;
            r_count     <= '0;
            r_index     <= '0;
            r_slot      <= '0;
            r_emit_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_last_edge <= n_last_edge;
            r_count     <= n_count;
            r_index     <= n_index;
            r_slot      <= n_slot;
            r_emit_n    <= n_emit_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value       <= n_value;
        r_neg         <= n_neg;
        r_out_channel <= n_out_channel;
        r_out_value   <= n_out_value;
        r_out_last    <= n_out_last;
        if (w_st_we) begin
            r_store[w_st_addr] <= w_interval;
        end
        if (r_state == pfd_pkg::SEQ_READ) begin
            r_pulse <= r_store[r_slot];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.channel = r_out_channel;
    assign o_out.value   = r_out_value;
    assign o_out.last    = r_out_last;

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == pfd_pkg::SEQ_DIV))
        else $error("divider done outside of divide state");

    // readout never walks past the frame length
    a_slot_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pfd_pkg::SEQ_IDLE) |-> ({1'b0, r_slot} < r_emit_n))
        else $error("readout slot beyond frame length");

    // normalized results stay within full deflection
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_use_us) |->
            (($signed(r_out_value) <= 16'sd256) && ($signed(r_out_value) >= -16'sd256)))
        else $error("normalized value out of range");
`endif

endmodule
